// ----- hw/rtl/bts_pkg.sv -----
// Package for the buzzer tone sequencer: request, configuration and result types,
// request and register codes, step timing constants and the envelope volume table.
// Depends on nothing; bts_step_core and buzzer_tone_sequencer import it.
package bts_pkg;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ENV   = 3'd1;
    localparam logic [2:0] REQ_PLAIN = 3'd2;
    localparam logic [2:0] REQ_TABLE = 3'd3;
    localparam logic [2:0] REQ_LOAD  = 3'd4;

    localparam logic [1:0] CFG_TICK_STEP   = 2'd0;
    localparam logic [1:0] CFG_TAIL_SILENT = 2'd1;
    localparam logic [1:0] CFG_SOFT_TONE   = 2'd2;
    localparam logic [1:0] CFG_QUIET_TONE  = 2'd3;

    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_ENV   = 2'd1;
    localparam logic [1:0] MODE_PLAIN = 2'd2;

    localparam logic [7:0]  ENV_STEPS       = 8'd102;
    localparam logic [7:0]  ENV_GAP_INDEX   = 8'd50;
    localparam logic [7:0]  ENV_PAUSE_INDEX = 8'd101;
    localparam logic [15:0] ENV_GAP_MS      = 16'd40;
    localparam logic [15:0] ENV_SAMPLE_MS   = 16'd1;
    localparam logic [7:0]  BEEP_STEPS      = 8'd42;
    localparam logic [7:0]  BEEP_GAP_INDEX  = 8'd20;
    localparam logic [7:0]  BEEP_PAUSE_INDEX = 8'd41;
    localparam logic [15:0] BEEP_MS         = 16'd20;
    localparam logic [15:0] BEEP_GAP_MS     = 16'd5;
    localparam logic [6:0]  BEEP_VOLUME     = 7'd40;
    localparam logic [6:0]  BEEP_START_VOL  = 7'd50;
    localparam logic [15:0] END_STEP_MS     = 16'd1;

    localparam logic [7:0]  TICK_STEP_RESET   = 8'd15;
    localparam logic [15:0] TAIL_SILENT_RESET = 16'd250;
    localparam logic [15:0] SOFT_TONE_RESET   = 16'd2800;
    localparam logic [15:0] QUIET_TONE_RESET  = 16'd3100;

    localparam logic [6:0] ENV_ROM [0:101] = '{
        7'd16, 7'd24, 7'd32, 7'd44, 7'd48, 7'd56, 7'd64, 7'd76, 7'd81, 7'd78,
        7'd73, 7'd70, 7'd65, 7'd61, 7'd57, 7'd52, 7'd49, 7'd45, 7'd42, 7'd42,
        7'd41, 7'd41, 7'd41, 7'd41, 7'd41, 7'd40, 7'd40, 7'd40, 7'd40, 7'd39,
        7'd39, 7'd36, 7'd34, 7'd33, 7'd31, 7'd30, 7'd29, 7'd27, 7'd25, 7'd23,
        7'd21, 7'd19, 7'd16, 7'd14, 7'd11, 7'd9,  7'd6,  7'd5,  7'd3,  7'd2,
        7'd0,
        7'd16, 7'd24, 7'd32, 7'd44, 7'd48, 7'd56, 7'd64, 7'd76, 7'd81, 7'd78,
        7'd73, 7'd70, 7'd65, 7'd61, 7'd57, 7'd52, 7'd49, 7'd45, 7'd42, 7'd42,
        7'd41, 7'd41, 7'd41, 7'd41, 7'd41, 7'd40, 7'd40, 7'd40, 7'd40, 7'd39,
        7'd39, 7'd36, 7'd34, 7'd33, 7'd31, 7'd30, 7'd29, 7'd27, 7'd25, 7'd23,
        7'd21, 7'd19, 7'd16, 7'd14, 7'd11, 7'd9,  7'd6,  7'd5,  7'd3,  7'd2,
        7'd0
    };

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] first_freq;
        logic [15:0] second_freq;
        logic [15:0] pause_ms;
        logic [6:0]  start_volume;
        logic [6:0]  sequence_length;
        logic [5:0]  entry_index;
        logic [15:0] entry_tone;
        logic [15:0] entry_duration_ms;
    } req_t;

    typedef struct packed {
        logic [7:0]  tick_step_ms;
        logic [15:0] tail_silence_ms;
        logic [15:0] soft_tone_threshold;
        logic [15:0] quiet_tone_threshold;
    } cfg_t;

    typedef struct packed {
        logic        sound_update;
        logic [6:0]  volume;
        logic [15:0] frequency;
        logic        sound_off;
        logic        busy_res;
    } res_t;

    function automatic logic [6:0] env_volume(input logic [7:0] idx);
        logic [6:0] vol;
        vol = 7'd0;
        if (idx < ENV_STEPS)
        begin
            vol = ENV_ROM[idx[6:0]];
        end
        return vol;
    endfunction

endpackage

// ----- hw/rtl/bts_table_mem.sv -----
// Tone and duration store of the table mode: one write port, one registered read port.
// A write to the address being read is forwarded into the read register.
// Depends on nothing outside this file.
module bts_table_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wtone,
    input  logic [15:0]       wlen,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rtone,
    output logic [15:0]       rlen
);

    logic [31:0] mem [0:DEPTH-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtone, wlen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= {wtone, wlen};
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rtone = rdata_reg[31:16];
    assign rlen  = rdata_reg[15:0];

endmodule

// ----- hw/rtl/bts_step_core.sv -----
// Sequencer state and single-pass step logic of the buzzer tone sequencer.
// Depends on bts_pkg and instantiates bts_table_mem for the loaded table.
module bts_step_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  bts_pkg::req_t req,
    input  bts_pkg::cfg_t cfg,
    output bts_pkg::res_t res
);

    import bts_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [7:0] DEPTH8 = 8'(TABLE_DEPTH);

    logic        running_reg, running_next;
    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  step_index_reg, step_index_next;
    logic [7:0]  step_count_reg, step_count_next;
    logic [15:0] time_left_reg, time_left_next;
    logic [6:0]  cur_vol_reg, cur_vol_next;
    logic [15:0] tone_one_reg, tone_one_next;
    logic [15:0] tone_two_reg, tone_two_next;
    logic [15:0] pause_len_reg, pause_len_next;

    logic [15:0] rd_tone;
    logic [15:0] rd_len;
    logic        load_we;
    logic [7:0]  slot8;
    logic [7:0]  len8;

    logic [15:0] step_tone;
    logic [15:0] step_time;
    logic [6:0]  step_vol;
    logic [6:0]  step_cur_vol;
    logic        in_seq;
    logic        tbl_hit;

    assign slot8   = {2'b00, req.entry_index};
    assign len8    = {1'b0, req.sequence_length};
    assign load_we = fire && (req.req_type == REQ_LOAD) && (slot8 < DEPTH8);

    bts_table_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot8[ADDR_W-1:0]),
        .wtone (req.entry_tone),
        .wlen  (req.entry_duration_ms),
        .raddr (step_index_next[ADDR_W-1:0]),
        .rtone (rd_tone),
        .rlen  (rd_len)
    );

    always_comb
    begin
        in_seq       = step_index_reg < step_count_reg;
        tbl_hit      = in_seq && (step_index_reg < DEPTH8);
        step_tone    = 16'd0;
        step_time    = END_STEP_MS;
        step_cur_vol = cur_vol_reg;
        step_vol     = cur_vol_reg;
        if (mode_reg == MODE_TABLE)
        begin
            if (tbl_hit)
            begin
                step_tone = rd_tone;
                step_time = rd_len;
            end
            else
            begin
                step_time = cfg.tail_silence_ms;
            end
            if (step_tone >= cfg.quiet_tone_threshold)
            begin
                step_vol = {2'b00, cur_vol_reg[6:2]};
            end
            else if (step_tone >= cfg.soft_tone_threshold)
            begin
                step_vol = {1'b0, cur_vol_reg[6:1]};
            end
        end
        else if (in_seq)
        begin
            if (mode_reg == MODE_ENV)
            begin
                if (step_index_reg < ENV_GAP_INDEX)
                begin
                    step_tone = tone_one_reg;
                end
                else if ((step_index_reg > ENV_GAP_INDEX) &&
                         (step_index_reg < ENV_PAUSE_INDEX))
                begin
                    step_tone = tone_two_reg;
                end
                if (step_index_reg == ENV_PAUSE_INDEX)
                begin
                    step_time    = pause_len_reg;
                    step_cur_vol = 7'd0;
                end
                else
                begin
                    step_time    = (step_index_reg == ENV_GAP_INDEX) ? ENV_GAP_MS
                                                                      : ENV_SAMPLE_MS;
                    step_cur_vol = env_volume(step_index_reg);
                end
            end
            else
            begin
                if (step_index_reg < BEEP_GAP_INDEX)
                begin
                    step_tone = tone_one_reg;
                    step_time = BEEP_MS;
                end
                else if (step_index_reg == BEEP_GAP_INDEX)
                begin
                    step_time = BEEP_GAP_MS;
                end
                else if (step_index_reg < BEEP_PAUSE_INDEX)
                begin
                    step_tone = tone_two_reg;
                    step_time = BEEP_MS;
                end
                if (step_index_reg == BEEP_PAUSE_INDEX)
                begin
                    step_time    = pause_len_reg;
                    step_cur_vol = 7'd0;
                end
                else
                begin
                    step_cur_vol = BEEP_VOLUME;
                end
            end
            step_vol = step_cur_vol;
        end
    end

    always_comb
    begin
        running_next    = running_reg;
        mode_next       = mode_reg;
        step_index_next = step_index_reg;
        step_count_next = step_count_reg;
        time_left_next  = time_left_reg;
        cur_vol_next    = cur_vol_reg;
        tone_one_next   = tone_one_reg;
        tone_two_next   = tone_two_reg;
        pause_len_next  = pause_len_reg;
        res             = '0;

        case (req.req_type)
            REQ_TICK:
            begin
                if (running_reg)
                begin
                    if (time_left_reg > {8'd0, cfg.tick_step_ms})
                    begin
                        time_left_next = time_left_reg - {8'd0, cfg.tick_step_ms};
                    end
                    else if ({1'b0, step_index_reg} == ({1'b0, step_count_reg} + 9'd1))
                    begin
                        running_next  = 1'b0;
                        res.sound_off = 1'b1;
                    end
                    else
                    begin
                        time_left_next   = step_time;
                        cur_vol_next     = step_cur_vol;
                        step_index_next  = step_index_reg + 8'd1;
                        res.sound_update = 1'b1;
                        res.volume       = step_vol;
                        res.frequency    = step_tone;
                    end
                end
            end
            REQ_ENV, REQ_PLAIN:
            begin
                res.sound_off   = 1'b1;
                tone_one_next   = req.first_freq;
                tone_two_next   = req.second_freq;
                pause_len_next  = req.pause_ms;
                running_next    = 1'b1;
                step_index_next = 8'd0;
                time_left_next  = 16'd0;
                if (req.req_type == REQ_ENV)
                begin
                    mode_next       = MODE_ENV;
                    step_count_next = ENV_STEPS;
                end
                else
                begin
                    mode_next       = MODE_PLAIN;
                    step_count_next = BEEP_STEPS;
                    cur_vol_next    = BEEP_START_VOL;
                end
            end
            REQ_TABLE:
            begin
                res.sound_off   = 1'b1;
                running_next    = 1'b1;
                mode_next       = MODE_TABLE;
                step_count_next = (len8 > DEPTH8) ? DEPTH8 : len8;
                step_index_next = 8'd0;
                time_left_next  = 16'd0;
                cur_vol_next    = req.start_volume;
            end
            default:
            begin
            end
        endcase

        res.busy_res = running_next;

        if (!fire)
        begin
            running_next    = running_reg;
            mode_next       = mode_reg;
            step_index_next = step_index_reg;
            step_count_next = step_count_reg;
            time_left_next  = time_left_reg;
            cur_vol_next    = cur_vol_reg;
            tone_one_next   = tone_one_reg;
            tone_two_next   = tone_two_reg;
            pause_len_next  = pause_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            mode_reg       <= MODE_TABLE;
            step_index_reg <= 8'd0;
            step_count_reg <= 8'd0;
            time_left_reg  <= 16'd0;
            cur_vol_reg    <= 7'd0;
            tone_one_reg   <= 16'd0;
            tone_two_reg   <= 16'd0;
            pause_len_reg  <= 16'd0;
        end
        else
        begin
            running_reg    <= running_next;
            mode_reg       <= mode_next;
            step_index_reg <= step_index_next;
            step_count_reg <= step_count_next;
            time_left_reg  <= time_left_next;
            cur_vol_reg    <= cur_vol_next;
            tone_one_reg   <= tone_one_next;
            tone_two_reg   <= tone_two_next;
            pause_len_reg  <= pause_len_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        step_count_reg <= ENV_STEPS)
        else $error("step count above the longest sequence");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> ({1'b0, step_index_reg} <= ({1'b0, step_count_reg} + 9'd1)))
        else $error("step index ran past the silent end step");

    a_update_moves_index: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.sound_update) |=> (step_index_reg == $past(step_index_reg) + 8'd1))
        else $error("applied step did not advance the step index");

endmodule

// ----- hw/rtl/buzzer_tone_sequencer.sv -----
// Top level of the buzzer tone sequencer: configuration registers, input register,
// result register and the step core. Depends on bts_pkg, bts_step_core, bts_table_mem.
//
// Channel   Direction  Handshake             Contents
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_stall   req_type and the request fields
// out       out        out_valid / out_stall sound_update, volume, frequency, sound_off,
//                                            busy_res
//
// One item per cycle unless stalled; items go from input register to result register.
// The step logic sits between the input register and the result register.
// The table store read is registered and prefetched at the next step index.
// Reset clears the sequencer, presets the config; the table holds garbage until loaded.
// A stalled result holds the result register, and the input register stalls behind it.
module buzzer_tone_sequencer #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [15:0] first_freq,
    input  logic [15:0] second_freq,
    input  logic [15:0] pause_ms,
    input  logic [6:0]  start_volume,
    input  logic [6:0]  sequence_length,
    input  logic [5:0]  entry_index,
    input  logic [15:0] entry_tone,
    input  logic [15:0] entry_duration_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sound_update,
    output logic [6:0]  volume,
    output logic [15:0] frequency,
    output logic        sound_off,
    output logic        busy_res
);

    import bts_pkg::*;

    cfg_t cfg_reg;
    logic s1_valid_reg, s1_valid_next;
    req_t s1_req_reg;
    logic out_valid_reg, out_valid_next;
    res_t res_reg;
    res_t core_res;
    logic s1_fire;
    logic in_xfer;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step_ms         <= TICK_STEP_RESET;
            cfg_reg.tail_silence_ms      <= TAIL_SILENT_RESET;
            cfg_reg.soft_tone_threshold  <= SOFT_TONE_RESET;
            cfg_reg.quiet_tone_threshold <= QUIET_TONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_STEP:   cfg_reg.tick_step_ms         <= cfg_data[7:0];
                CFG_TAIL_SILENT: cfg_reg.tail_silence_ms      <= cfg_data;
                CFG_SOFT_TONE:   cfg_reg.soft_tone_threshold  <= cfg_data;
                CFG_QUIET_TONE:  cfg_reg.quiet_tone_threshold <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_req_reg.req_type          <= req_type;
            s1_req_reg.first_freq        <= first_freq;
            s1_req_reg.second_freq       <= second_freq;
            s1_req_reg.pause_ms          <= pause_ms;
            s1_req_reg.start_volume      <= start_volume;
            s1_req_reg.sequence_length   <= sequence_length;
            s1_req_reg.entry_index       <= entry_index;
            s1_req_reg.entry_tone        <= entry_tone;
            s1_req_reg.entry_duration_ms <= entry_duration_ms;
        end
        if (s1_fire)
        begin
            res_reg <= core_res;
        end
    end

    bts_step_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .req   (s1_req_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign out_valid    = out_valid_reg;
    assign sound_update = res_reg.sound_update;
    assign volume       = res_reg.volume;
    assign frequency    = res_reg.frequency;
    assign sound_off    = res_reg.sound_off;
    assign busy_res     = res_reg.busy_res;

    a_update_not_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.sound_update && res_reg.sound_off))
        else $error("a result both applies a step and switches audio off");

    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.sound_update) |-> res_reg.busy_res)
        else $error("a step was applied while the sequencer is stopped");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg)
        else $error("input register dropped an item that was not processed");

endmodule
